// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/cct_pkg.sv
// ---------------------------------------------------------------------------
// Compare/capture timer package
// Command, address and configuration codes plus the mask helper functions.
// ---------------------------------------------------------------------------
package cct_pkg;

  localparam int NUM_CHANNELS_DEF = 4;

  localparam int CMD_W   = 2;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int PRE_W   = 9;

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [ADDR_W-1:0] ADDR_START    = 5'd0;
  localparam logic [ADDR_W-1:0] ADDR_STOP     = 5'd1;
  localparam logic [ADDR_W-1:0] ADDR_CLEAR    = 5'd2;
  localparam logic [ADDR_W-1:0] ADDR_SHUTDOWN = 5'd3;
  localparam logic [ADDR_W-1:0] ADDR_SHORTS   = 5'd4;
  localparam logic [ADDR_W-1:0] ADDR_INTENSET = 5'd5;
  localparam logic [ADDR_W-1:0] ADDR_INTENCLR = 5'd6;

  localparam logic [1:0] GRP_TASKS   = 2'd0;
  localparam logic [1:0] GRP_CAPTURE = 2'd1;
  localparam logic [1:0] GRP_EVENT   = 2'd2;
  localparam logic [1:0] GRP_COMPARE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 1'b1;

  localparam logic [3:0] PRESCALE_RESET = 4'd4;
  localparam logic [3:0] PRESCALE_MAX   = 4'd9;
  localparam logic [1:0] WIDTH_RESET    = 2'd1;

  function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] mode);
    logic [DATA_W-1:0] m;
    unique case (mode)
      2'd0:    m = 32'h0000_00ff;
      2'd1:    m = 32'h0000_ffff;
      2'd2:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic [PRE_W-1:0] prescale_mask(input logic [3:0] shift);
    logic [3:0]     s;
    logic [PRE_W:0] p;
    s = (shift > PRESCALE_MAX) ? PRESCALE_MAX : shift;
    p = (10'd1 << s) - 10'd1;
    return p[PRE_W-1:0];
  endfunction

endpackage

// File: rtl/core/compare_capture_timer.sv
// ---------------------------------------------------------------------------
// Compare/capture timer
// Prescaled counter with compare/capture channels, driven by tick and
// register access transactions, one result transaction per input.
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------
//   in      | input     | in_valid / in_ready | in_cmd, in_reg_addr, in_wdata
//   out     | output    | out_valid/out_ready | out_rdata, out_irq
//   cfg     | input     | cfg_we              | cfg_index, cfg_wdata
//
// Every transaction is handled in the cycle it is accepted; its result is
// registered, so one transaction per cycle while in_ready stays high.
// The output register and a one-entry skid stage let a new transaction in
// while a result waits; in_ready drops only when both hold results.
// Reset is synchronous; it clears the timer state and loads the prescale and width defaults, with no clearing pass.

module compare_capture_timer #(
  parameter int NUM_CHANNELS = cct_pkg::NUM_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cct_pkg::CMD_W-1:0]     in_cmd,
  input  logic [cct_pkg::ADDR_W-1:0]    in_reg_addr,
  input  logic [cct_pkg::DATA_W-1:0]    in_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cct_pkg::DATA_W-1:0]    out_rdata,
  output logic                          out_irq,
  input  logic                          cfg_we,
  input  logic [cct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cct_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cct_pkg::*;
  `include "assert_macros.svh"

  logic [3:0]              prescale_r;
  logic [1:0]              width_r;
  logic [DATA_W-1:0]       cnt_r, cnt_nxt;
  logic [PRE_W-1:0]        pre_r, pre_nxt;
  logic                    running_r, running_nxt;
  logic [DATA_W-1:0]       cmp_r [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] cmp_we;
  logic [DATA_W-1:0]       cmp_wval;
  logic [NUM_CHANNELS-1:0] ev_r, ev_nxt;
  logic [NUM_CHANNELS-1:0] ien_r, ien_nxt;
  logic [NUM_CHANNELS-1:0] shorts_r, shorts_nxt;

  logic                    out_v_r, skid_v_r;
  logic [DATA_W-1:0]       out_rdata_r, skid_rdata_r;
  logic                    out_irq_r, skid_irq_r;

  logic                    accept;
  logic [DATA_W-1:0]       res_rdata;
  logic                    res_irq;

  logic [DATA_W-1:0]       wmask;
  logic [PRE_W-1:0]        pmask;
  logic [PRE_W-1:0]        pre_inc;
  logic [DATA_W-1:0]       cnt_inc;
  logic [NUM_CHANNELS-1:0] match;
  logic [2:0]              ch;
  logic                    ch_ok;
  logic [1:0]              grp;
  logic                    fire;
  logic [DATA_W-1:0]       cmp_rd;

  assign accept   = in_valid && in_ready;
  assign in_ready = !skid_v_r;

  assign wmask = width_mask(width_r);
  assign pmask = prescale_mask(prescale_r);
  assign pre_inc = (pre_r + PRE_W'(1)) & pmask;
  assign cnt_inc = (cnt_r + DATA_W'(1)) & wmask;
  assign ch    = in_reg_addr[2:0];
  assign grp   = in_reg_addr[4:3];
  assign ch_ok = {29'd0, ch} < NUM_CHANNELS;
  assign fire  = in_wdata[0];

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      match[i] = (cmp_r[i] & wmask) == cnt_inc;
    end
  end

  always_comb begin
    cmp_rd = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (ch == 3'(i)) begin
        cmp_rd = cmp_r[i];
      end
    end
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    pre_nxt     = pre_r;
    running_nxt = running_r;
    ev_nxt      = ev_r;
    ien_nxt     = ien_r;
    shorts_nxt  = shorts_r;
    cmp_we      = '0;
    cmp_wval    = in_wdata;
    res_rdata   = '0;
    unique case (in_cmd)
      CMD_TICK: begin
        if (running_r) begin
          pre_nxt = pre_inc;
          if (pre_inc == '0) begin
            ev_nxt  = ev_r | match;
            cnt_nxt = |(match & shorts_r) ? '0 : cnt_inc;
          end
        end
      end
      CMD_WRITE: begin
        if (grp == GRP_TASKS) begin
          priority case (in_reg_addr)
            ADDR_START: begin
              if (fire) running_nxt = 1'b1;
            end
            ADDR_STOP, ADDR_SHUTDOWN: begin
              if (fire) running_nxt = 1'b0;
            end
            ADDR_CLEAR: begin
              if (fire) begin
                cnt_nxt = '0;
                pre_nxt = '0;
              end
            end
            ADDR_SHORTS:   shorts_nxt = in_wdata[NUM_CHANNELS-1:0];
            ADDR_INTENSET: ien_nxt = ien_r | in_wdata[NUM_CHANNELS-1:0];
            ADDR_INTENCLR: ien_nxt = ien_r & ~in_wdata[NUM_CHANNELS-1:0];
            default: ;
          endcase
        end else if (ch_ok) begin
          unique case (grp)
            GRP_CAPTURE: begin
              cmp_wval = cnt_r;
              for (int i = 0; i < NUM_CHANNELS; i++) begin
                cmp_we[i] = fire && (ch == 3'(i));
              end
            end
            GRP_EVENT: begin
              for (int i = 0; i < NUM_CHANNELS; i++) begin
                if (ch == 3'(i)) ev_nxt[i] = fire;
              end
            end
            default: begin
              for (int i = 0; i < NUM_CHANNELS; i++) begin
                cmp_we[i] = (ch == 3'(i));
              end
            end
          endcase
        end
      end
      CMD_READ: begin
        if (in_reg_addr == ADDR_SHORTS) begin
          res_rdata = DATA_W'(shorts_r);
        end else if (in_reg_addr == ADDR_INTENSET || in_reg_addr == ADDR_INTENCLR) begin
          res_rdata = DATA_W'(ien_r);
        end else if (ch_ok && grp == GRP_EVENT) begin
          res_rdata = DATA_W'(ev_r[ch[$clog2(NUM_CHANNELS > 1 ? NUM_CHANNELS : 2)-1:0]]);
        end else if (ch_ok && grp == GRP_COMPARE) begin
          res_rdata = cmp_rd;
        end
      end
      default: ;
    endcase
    res_irq = |(ev_nxt & ien_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= PRESCALE_RESET;
      width_r    <= WIDTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRESCALE: prescale_r <= cfg_wdata;
        default:      width_r    <= cfg_wdata[1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      pre_r     <= '0;
      running_r <= 1'b0;
      ev_r      <= '0;
      ien_r     <= '0;
      shorts_r  <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cmp_r[i] <= '0;
      end
    end else if (accept) begin
      cnt_r     <= cnt_nxt;
      pre_r     <= pre_nxt;
      running_r <= running_nxt;
      ev_r      <= ev_nxt;
      ien_r     <= ien_nxt;
      shorts_r  <= shorts_nxt;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (cmp_we[i]) cmp_r[i] <= cmp_wval;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (!out_v_r || out_ready) begin
        out_v_r  <= skid_v_r || accept;
        skid_v_r <= 1'b0;
      end else if (accept) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_rdata_r <= skid_rdata_r;
        out_irq_r   <= skid_irq_r;
      end else if (accept) begin
        out_rdata_r <= res_rdata;
        out_irq_r   <= res_irq;
      end
    end else if (accept) begin
      skid_rdata_r <= res_rdata;
      skid_irq_r   <= res_irq;
    end
  end

  assign out_valid = out_v_r;
  assign out_rdata = out_rdata_r;
  assign out_irq   = out_irq_r;

  `ASSERT_AT(a_skid_behind_out, clk, rst_n, !skid_v_r || out_v_r)
  `ASSERT_NEXT(a_stall_fills_skid, clk, rst_n, accept && out_v_r && !out_ready, skid_v_r)
  `ASSERT_NEXT(a_stopped_tick_holds, clk, rst_n, accept && in_cmd == CMD_TICK && !running_r, $stable(cnt_r) && $stable(pre_r))

endmodule
